// ===== rtl/core/escape_sequence_decoder_unit_macros.svh =====
// Assertion macros shared by the escape sequence decoder RTL.
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/esd_pkg.sv =====
// Package with widths, character codes and the hex digit function of the escape decoder.
`timescale 1ns / 1ps
`default_nettype none
package esd_pkg;

   // Field widths.
   localparam int unsigned CharWidth  = 21;
   localparam int unsigned OutWidth   = 22;
   localparam int unsigned AccumWidth = 18;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned DigitWidth = 5;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned AddrWidth  = 3;

   // Register index of the epsilon code, taken from paddr[2].
   localparam logic RegEpsilon = 1'b0;

   // Escape selector characters.
   localparam logic [CharWidth-1:0] ChBackslash = 21'h00005C;
   localparam logic [CharWidth-1:0] ChA = 21'h000061;
   localparam logic [CharWidth-1:0] ChB = 21'h000062;
   localparam logic [CharWidth-1:0] ChE = 21'h000065;
   localparam logic [CharWidth-1:0] ChF = 21'h000066;
   localparam logic [CharWidth-1:0] ChN = 21'h00006E;
   localparam logic [CharWidth-1:0] ChR = 21'h000072;
   localparam logic [CharWidth-1:0] ChT = 21'h000074;
   localparam logic [CharWidth-1:0] ChV = 21'h000076;
   localparam logic [CharWidth-1:0] ChX = 21'h000078;
   localparam logic [CharWidth-1:0] ChU = 21'h000075;

   // Control codes produced by the simple escapes.
   localparam logic [OutWidth-1:0] CodeBell      = 22'd7;
   localparam logic [OutWidth-1:0] CodeBackspace = 22'd8;
   localparam logic [OutWidth-1:0] CodeTab       = 22'd9;
   localparam logic [OutWidth-1:0] CodeNewline   = 22'd10;
   localparam logic [OutWidth-1:0] CodeVtab      = 22'd11;
   localparam logic [OutWidth-1:0] CodeFormfeed  = 22'd12;
   localparam logic [OutWidth-1:0] CodeReturn    = 22'd13;

   // Digit counts for the two hex escapes.
   localparam logic [CountWidth-1:0] DigitsX = 3'd2;
   localparam logic [CountWidth-1:0] DigitsU = 3'd4;

   // Value of one hex digit; any other character counts as -1.
   function automatic logic signed [DigitWidth-1:0] hex_digit(input logic [CharWidth-1:0] c);
      logic signed [DigitWidth-1:0] d;
      d = -5'sd1;
      case (c) inside
         [21'h000030:21'h000039]: d = signed'({1'b0, c[3:0]});
         [21'h000041:21'h000046],
         [21'h000061:21'h000066]: d = signed'(5'({1'b0, c[3:0]}) + 5'd9);
         default: d = -5'sd1;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/escape_sequence_decoder_unit.sv =====
// A word in the input register is decoded into the result register, one word per cycle
// unless the result stalls. Escape and hex digit words update the state without a result.
// The input register lets a new word in while a finished result still waits on the output.
// Each word's decode is a case select and one 18-bit shift-add on the hex accumulator.
// Reset is synchronous and active high: plain mode, empty stages, epsilon code zero.
`timescale 1ns / 1ps
`default_nettype none
`include "escape_sequence_decoder_unit_macros.svh"
module escape_sequence_decoder_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input channel.
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [esd_pkg::CharWidth-1:0]         req_char_in,
   // Result channel.
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [esd_pkg::OutWidth-1:0]        rsp_char_out,
   output logic                                       rsp_bad_hex,
   // Configuration port.
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [esd_pkg::AddrWidth-1:0]         csr_paddr,
   input  wire logic [esd_pkg::DataWidth-1:0]         csr_pwdata,
   output logic [esd_pkg::DataWidth-1:0]              csr_prdata,
   output logic                                       csr_pready
);

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX   = 2'd2
   } mode_type;

   // Registers.
   logic                                       s1_valid_ff;
   logic [esd_pkg::CharWidth-1:0]              s1_char_ff;
   logic                                       out_valid_ff;
   logic signed [esd_pkg::OutWidth-1:0]        out_char_ff;
   logic                                       out_bad_ff;
   mode_type                                   mode_ff;
   logic [esd_pkg::CountWidth-1:0]             digits_ff;
   logic signed [esd_pkg::AccumWidth-1:0]      accum_ff;
   logic                                       saw_bad_ff;
   logic [esd_pkg::CharWidth-1:0]              epsilon_ff;

   // Next values.
   mode_type                                   mode_in;
   logic [esd_pkg::CountWidth-1:0]             digits_in;
   logic signed [esd_pkg::AccumWidth-1:0]      accum_in;
   logic                                       saw_bad_in;
   logic                                       emit_in;
   logic signed [esd_pkg::OutWidth-1:0]        out_char_in;
   logic                                       out_bad_in;

   logic                                       s1_go;
   logic                                       req_fire;
   logic                                       csr_write;
   logic signed [esd_pkg::DigitWidth-1:0]      digit;
   logic signed [esd_pkg::AccumWidth-1:0]      accum_sum;
   logic [esd_pkg::CountWidth-1:0]             digits_dec;
   logic                                       saw_bad_sum;

   // Handshakes: the decode stage moves when the result register is free or being emptied.
   assign s1_go     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_bad_hex  = out_bad_ff;

   // Register file read.
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == esd_pkg::RegEpsilon) begin
         csr_prdata = esd_pkg::DataWidth'(epsilon_ff);
      end
   end

   // Hex digit step: shift the accumulator by one digit and add the new one.
   assign digit       = esd_pkg::hex_digit(s1_char_ff);
   assign accum_sum   = {accum_ff[esd_pkg::AccumWidth-5:0], 4'h0}
                        + esd_pkg::AccumWidth'(digit);
   assign digits_dec  = digits_ff - 3'd1;
   assign saw_bad_sum = saw_bad_ff || digit[esd_pkg::DigitWidth-1];

   // Decode of the word in the input register.
   always_comb begin
      mode_in     = mode_ff;
      digits_in   = digits_ff;
      accum_in    = accum_ff;
      saw_bad_in  = saw_bad_ff;
      emit_in     = 1'b0;
      out_char_in = signed'(esd_pkg::OutWidth'(s1_char_ff));
      out_bad_in  = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            emit_in = 1'b1;
            case (s1_char_ff)
               esd_pkg::ChA: out_char_in = esd_pkg::CodeBell;
               esd_pkg::ChB: out_char_in = esd_pkg::CodeBackspace;
               esd_pkg::ChE: out_char_in = signed'(esd_pkg::OutWidth'(epsilon_ff));
               esd_pkg::ChF: out_char_in = esd_pkg::CodeFormfeed;
               esd_pkg::ChN: out_char_in = esd_pkg::CodeNewline;
               esd_pkg::ChR: out_char_in = esd_pkg::CodeReturn;
               esd_pkg::ChT: out_char_in = esd_pkg::CodeTab;
               esd_pkg::ChV: out_char_in = esd_pkg::CodeVtab;
               esd_pkg::ChX, esd_pkg::ChU: begin
                  mode_in    = MODE_HEX;
                  digits_in  = (s1_char_ff == esd_pkg::ChX) ? esd_pkg::DigitsX
                                                            : esd_pkg::DigitsU;
                  accum_in   = '0;
                  saw_bad_in = 1'b0;
                  emit_in    = 1'b0;
               end
               default: out_char_in = signed'(esd_pkg::OutWidth'(s1_char_ff));
            endcase
         end
         MODE_HEX: begin
            // A count that wraps from zero also finishes the escape.
            if (digits_dec == 3'd0 || digits_dec == 3'd7) begin
               emit_in     = 1'b1;
               out_char_in = esd_pkg::OutWidth'(accum_sum);
               out_bad_in  = saw_bad_sum;
               mode_in     = MODE_PLAIN;
               digits_in   = '0;
               accum_in    = '0;
               saw_bad_in  = 1'b0;
            end else begin
               digits_in  = digits_dec;
               accum_in   = accum_sum;
               saw_bad_in = saw_bad_sum;
            end
         end
         default: begin
            // Plain mode; the unused mode code behaves the same way.
            mode_in = MODE_PLAIN;
            if (s1_char_ff == esd_pkg::ChBackslash) begin
               mode_in = MODE_ESC;
            end else begin
               emit_in = 1'b1;
            end
         end
      endcase
   end

   // State, pipeline and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_PLAIN;
         digits_ff    <= '0;
         accum_ff     <= '0;
         saw_bad_ff   <= 1'b0;
         epsilon_ff   <= '0;
      end else begin
         if (csr_write && csr_paddr[2] == esd_pkg::RegEpsilon) begin
            epsilon_ff <= csr_pwdata[esd_pkg::CharWidth-1:0];
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_ready || !out_valid_ff) begin
            out_valid_ff <= s1_go && emit_in;
         end
         if (s1_go) begin
            mode_ff    <= mode_in;
            digits_ff  <= digits_in;
            accum_ff   <= accum_in;
            saw_bad_ff <= saw_bad_in;
         end
      end
      if (req_fire) begin
         s1_char_ff <= req_char_in;
      end
      if (s1_go && emit_in) begin
         out_char_ff <= out_char_in;
         out_bad_ff  <= out_bad_in;
      end
   end

   // Checks on the decoder's own state and stages.
   `ESD_ASSERT_NOW(a_hex_count, clock, reset, mode_ff == MODE_HEX, digits_ff != 3'd0,
      "hex mode with no digits pending")
   `ESD_ASSERT_NOW(a_idle_clean, clock, reset, mode_ff != MODE_HEX,
      digits_ff == 3'd0 && accum_ff == '0 && !saw_bad_ff,
      "hex state not cleared outside hex mode")
   `ESD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_go,
      s1_valid_ff && $stable(s1_char_ff), "stalled input word lost or changed")
   `ESD_ASSERT_NEXT(a_no_phantom, clock, reset, !out_valid_ff && !s1_valid_ff,
      !out_valid_ff, "result appeared without a decoded word")

endmodule
`default_nettype wire
